// ===== design/rpc_pkg.sv =====
// shared types and constants for the range to prefix cover unit
`default_nettype none

package rpc_pkg;

	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned PREFIX_W = 6;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned MAX_NETS = 62;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic final_net;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/range_to_prefix_cover_unit.sv =====
// top level: splits an address range into its minimal list of prefix networks
`default_nettype none

// A range is taken when start is high and busy is low; reversed bounds are swapped
// and both bounds are cut to ADDR_BITS bits. The cover then comes out one network
// per cycle in ascending order, each shown for a single cycle with result_valid, the
// final one marked by is_last; the receiver cannot stall, so it must take every
// strobe. After the load cycle busy stays high while the item's networks are stepped
// out by the size/advance loop in the datapath, which retires one network per cycle.
// The next range may start while the last network of the previous one is shown.
module range_to_prefix_cover_unit #(
	parameter int unsigned ADDR_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rpc_pkg::FIELD_W-1:0]   range_low,
	input  wire logic [rpc_pkg::FIELD_W-1:0]   range_high,
	output logic                               result_valid,
	output logic [rpc_pkg::FIELD_W-1:0]        net_base,
	output logic [rpc_pkg::PREFIX_W-1:0]       prefix_length,
	output logic [rpc_pkg::INDEX_W-1:0]        net_index,
	output logic                               is_last
);

	rpc_pkg::ctrl_cmd_t  cmd;
	rpc_pkg::dp_status_t status;

	rpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	rpc_datapath #(
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.range_low     (range_low),
		.range_high    (range_high),
		.status        (status),
		.result_valid  (result_valid),
		.net_base      (net_base),
		.prefix_length (prefix_length),
		.net_index     (net_index),
		.is_last       (is_last)
	);

endmodule

`default_nettype wire

// ===== design/rpc_ctrl.sv =====
// controller state machine: sequences load and per-network steps
`default_nettype none

module rpc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire rpc_pkg::dp_status_t status,
	output rpc_pkg::ctrl_cmd_t      cmd,
	output logic                    busy
);

	rpc_pkg::state_t state_q;
	rpc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.step  = 1'b0;
		busy      = 1'b0;
		unique case (state_q)
			rpc_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rpc_pkg::ST_RUN;
				end
			end
			rpc_pkg::ST_RUN: begin
				busy     = 1'b1;
				cmd.step = 1'b1;
				if (status.final_net) begin
					state_d = rpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/rpc_datapath.sv =====
// datapath: current low address, remaining span, network sizing and result registers
`default_nettype none

module rpc_datapath #(
	parameter int unsigned ADDR_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rpc_pkg::ctrl_cmd_t               cmd,
	input  wire logic [rpc_pkg::FIELD_W-1:0]      range_low,
	input  wire logic [rpc_pkg::FIELD_W-1:0]      range_high,
	output rpc_pkg::dp_status_t                   status,
	output logic                                  result_valid,
	output logic [rpc_pkg::FIELD_W-1:0]           net_base,
	output logic [rpc_pkg::PREFIX_W-1:0]          prefix_length,
	output logic [rpc_pkg::INDEX_W-1:0]           net_index,
	output logic                                  is_last
);

	localparam int unsigned SW = $clog2(ADDR_BITS + 1);

	logic [ADDR_BITS-1:0]      low_q;
	logic [ADDR_BITS:0]        rem_q;
	logic [rpc_pkg::INDEX_W-1:0] idx_q;

	logic [ADDR_BITS-1:0]      lo_in;
	logic [ADDR_BITS-1:0]      hi_in;
	logic [ADDR_BITS-1:0]      lo_sw;
	logic [ADDR_BITS-1:0]      hi_sw;
	logic [SW-1:0]             span_log;
	logic [SW-1:0]             tz_low;
	logic [SW-1:0]             s;
	logic [ADDR_BITS:0]        size;
	logic [ADDR_BITS:0]        rem_next;
	logic [ADDR_BITS:0]        low_next;
	logic                      done_net;
	logic                      result_valid_q;
	logic [rpc_pkg::FIELD_W-1:0]  base_q;
	logic [rpc_pkg::PREFIX_W-1:0] prefix_q;
	logic [rpc_pkg::INDEX_W-1:0]  index_q;
	logic                         last_q;

	// index of the highest set bit of a nonzero span
	function automatic logic [SW-1:0] msb_index(input logic [ADDR_BITS:0] v);
		logic [SW-1:0] k;
		k = '0;
		for (int i = 0; i <= ADDR_BITS; i++) begin
			if (v[i]) begin
				k = SW'(i);
			end
		end
		return k;
	endfunction

	// trailing zeros, ADDR_BITS for a zero address
	function automatic logic [SW-1:0] trail_zeros(input logic [ADDR_BITS-1:0] v);
		logic [SW-1:0] n;
		n = SW'(ADDR_BITS);
		for (int i = ADDR_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = SW'(i);
			end
		end
		return n;
	endfunction

	assign lo_in = range_low[ADDR_BITS-1:0];
	assign hi_in = range_high[ADDR_BITS-1:0];
	assign lo_sw = (hi_in < lo_in) ? hi_in : lo_in;
	assign hi_sw = (hi_in < lo_in) ? lo_in : hi_in;

	assign span_log = msb_index(rem_q);
	assign tz_low   = trail_zeros(low_q);
	assign s        = (tz_low < span_log) ? tz_low : span_log;
	assign size     = (ADDR_BITS + 1)'(1) << s;
	assign rem_next = rem_q - size;
	assign low_next = {1'b0, low_q} + size;

	// network reaches high exactly when it eats the whole remaining span
	assign done_net = (rem_next == '0);
	assign status.final_net = done_net || (idx_q == rpc_pkg::INDEX_W'(rpc_pkg::MAX_NETS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			low_q <= lo_sw;
			rem_q <= {1'b0, hi_sw} - {1'b0, lo_sw} + (ADDR_BITS + 1)'(1);
			idx_q <= '0;
		end else if (cmd.step) begin
			low_q <= low_next[ADDR_BITS-1:0];
			rem_q <= rem_next;
			idx_q <= idx_q + rpc_pkg::INDEX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			base_q   <= rpc_pkg::FIELD_W'(low_q);
			prefix_q <= rpc_pkg::PREFIX_W'(ADDR_BITS) - rpc_pkg::PREFIX_W'(s);
			index_q  <= idx_q;
			last_q   <= done_net;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.step;
		end
	end

	assign result_valid  = result_valid_q;
	assign net_base      = base_q;
	assign prefix_length = prefix_q;
	assign net_index     = index_q;
	assign is_last       = last_q;

endmodule

`default_nettype wire

// ===== design/rpc_checker.sv =====
// port-level checks for the range to prefix cover unit, bound to the top level
`default_nettype none

module rpc_checker #(
	parameter int unsigned ADDR_BITS = 32
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          result_valid,
	input wire logic [rpc_pkg::FIELD_W-1:0]   net_base,
	input wire logic [rpc_pkg::PREFIX_W-1:0]  prefix_length,
	input wire logic [rpc_pkg::INDEX_W-1:0]   net_index,
	input wire logic                          is_last
);

	// unused upper bits of the base port when addresses are narrower than the port
	localparam logic [rpc_pkg::PREFIX_W-1:0] PAD_BITS =
		rpc_pkg::PREFIX_W'(rpc_pkg::FIELD_W - ADDR_BITS);

	// an accepted range always yields at least one network
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("range accepted but unit not busy");

	// unit frees up together with the last network of a cover
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_last |-> !busy)
		else $error("still busy after last network");

	// networks of one cover come in consecutive cycles with rising index
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_last
			&& net_index != rpc_pkg::INDEX_W'(rpc_pkg::MAX_NETS - 1)
		|=> result_valid && net_index == $past(net_index) + rpc_pkg::INDEX_W'(1))
		else $error("gap or index jump inside a cover");

	// prefix fits the address width and base is aligned to it
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> prefix_length <= rpc_pkg::PREFIX_W'(ADDR_BITS)
			&& ((net_base << (prefix_length + PAD_BITS))
				>> (prefix_length + PAD_BITS)) == '0
			|| prefix_length == '0)
		else $error("network out of range or misaligned");

endmodule

bind range_to_prefix_cover_unit rpc_checker #(
	.ADDR_BITS (ADDR_BITS)
) u_rpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_valid  (result_valid),
	.net_base      (net_base),
	.prefix_length (prefix_length),
	.net_index     (net_index),
	.is_last       (is_last)
);

`default_nettype wire

// ===== sim/range_to_prefix_cover_checker.sv =====
// checker for the range to prefix cover unit: predicts each cover and compares results
`timescale 1ns / 100ps

module range_to_prefix_cover_checker #(
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [rpc_pkg::FIELD_W-1:0]   range_low,
	input  logic [rpc_pkg::FIELD_W-1:0]   range_high,
	input  logic                          result_valid,
	input  logic [rpc_pkg::FIELD_W-1:0]   net_base,
	input  logic [rpc_pkg::PREFIX_W-1:0]  prefix_length,
	input  logic [rpc_pkg::INDEX_W-1:0]   net_index,
	input  logic                          is_last,
	output int                            fail_count,
	output int                            pending_count
);

	typedef struct packed {
		logic [rpc_pkg::FIELD_W-1:0]  base;
		logic [rpc_pkg::PREFIX_W-1:0] plen;
		logic [rpc_pkg::INDEX_W-1:0]  idx;
		logic                         last;
	} prefix_net_t;

	prefix_net_t expected_nets[$];
	int errs = 0;

	// walk the range from its low end, taking the largest aligned block that fits
	function automatic void expand_range(input logic [rpc_pkg::FIELD_W-1:0] a,
			input logic [rpc_pkg::FIELD_W-1:0] b);
		logic [63:0] mask;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] tmp;
		logic [63:0] span;
		logic [63:0] fin;
		int          k;
		int          n;
		int          s;
		int          cnt;
		bit          done;
		prefix_net_t net;
		mask = (64'd1 << ADDR_BITS) - 64'd1;
		lo = {32'd0, a} & mask;
		hi = {32'd0, b} & mask;
		if (hi < lo) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		cnt = 0;
		done = 1'b0;
		while (!done && cnt < rpc_pkg::MAX_NETS) begin
			span = hi - lo + 64'd1;
			k = 0;
			tmp = span;
			while (tmp > 64'd1) begin
				tmp = tmp >> 1;
				k++;
			end
			n = 0;
			while (n < ADDR_BITS && lo[n] == 1'b0)
				n++;
			s = (n < k) ? n : k;
			fin = lo + ((64'd1 << s) - 64'd1);
			done = (fin >= hi);
			net.base = lo[rpc_pkg::FIELD_W-1:0];
			net.plen = rpc_pkg::PREFIX_W'(ADDR_BITS - s);
			net.idx = rpc_pkg::INDEX_W'(cnt);
			net.last = done;
			expected_nets.push_back(net);
			cnt++;
			lo = fin + 64'd1;
		end
	endfunction

	always @(posedge clk) begin
		prefix_net_t want;
		if (!arst_n) begin
			expected_nets.delete();
			errs = 0;
		end else begin
			// results first: a new range may be taken while the last network is shown
			if (result_valid) begin
				if (expected_nets.size() == 0) begin
					$display("%0t: unexpected network base=%h prefix=%0d index=%0d last=%b",
						$time, net_base, prefix_length, net_index, is_last);
					errs++;
				end else begin
					want = expected_nets.pop_front();
					if (net_base !== want.base) begin
						$display("%0t: net_base expected %h actual %h",
							$time, want.base, net_base);
						errs++;
					end
					if (prefix_length !== want.plen) begin
						$display("%0t: prefix_length expected %0d actual %0d",
							$time, want.plen, prefix_length);
						errs++;
					end
					if (net_index !== want.idx) begin
						$display("%0t: net_index expected %0d actual %0d",
							$time, want.idx, net_index);
						errs++;
					end
					if (is_last !== want.last) begin
						$display("%0t: is_last expected %b actual %b",
							$time, want.last, is_last);
						errs++;
					end
				end
			end
			if (start && !busy)
				expand_range(range_low, range_high);
		end
		fail_count <= errs;
		pending_count <= expected_nets.size();
	end

endmodule

// ===== sim/tb_range_to_prefix_cover_unit.sv =====
// testbench top for the range to prefix cover unit: stimulus and verdict
`timescale 1ns / 100ps

module tb_range_to_prefix_cover_unit;

	localparam int unsigned RANDOM_RANGES = 480;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [rpc_pkg::FIELD_W-1:0]   range_low;
	logic [rpc_pkg::FIELD_W-1:0]   range_high;
	logic                          result_valid;
	logic [rpc_pkg::FIELD_W-1:0]   net_base;
	logic [rpc_pkg::PREFIX_W-1:0]  prefix_length;
	logic [rpc_pkg::INDEX_W-1:0]   net_index;
	logic                          is_last;
	int                            fail_count;
	int                            pending_count;

	range_to_prefix_cover_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.range_low(range_low),
		.range_high(range_high),
		.result_valid(result_valid),
		.net_base(net_base),
		.prefix_length(prefix_length),
		.net_index(net_index),
		.is_last(is_last)
	);

	range_to_prefix_cover_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.range_low(range_low),
		.range_high(range_high),
		.result_valid(result_valid),
		.net_base(net_base),
		.prefix_length(prefix_length),
		.net_index(net_index),
		.is_last(is_last),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// hold start with the range until the unit takes it
	task automatic send_range(input logic [31:0] a, input logic [31:0] b);
		@(negedge clk);
		start = 1'b1;
		range_low = a;
		range_high = b;
		do
			@(posedge clk);
		while (busy);
	endtask

	// idle with junk on the range ports
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start = 1'b0;
		range_low = $urandom;
		range_high = $urandom;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_covers();
		@(negedge clk);
		start = 1'b0;
		while (pending_count != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0001;
			3: return 32'hFFFF_FFFE;
			4: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	initial begin
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mask;
		logic [32:0] sum;
		int          s;
		start = 1'b0;
		range_low = '0;
		range_high = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_cycles(2);

		// directed: single addresses, full space, reversed bounds, worst-case cover
		send_range(32'h0000_0000, 32'h0000_0000);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_range(32'h0000_0000, 32'hFFFF_FFFF);
		send_range(32'hFFFF_FFFF, 32'h0000_0000);
		send_range(32'h0000_0001, 32'hFFFF_FFFE);
		send_range(32'hFFFF_FFFE, 32'h0000_0001);
		send_range(32'h0000_0000, 32'hFFFF_FFFE);
		send_range(32'h0000_0001, 32'hFFFF_FFFF);
		send_range(32'h8000_0000, 32'hFFFF_FFFF);
		send_range(32'h0000_0000, 32'h7FFF_FFFF);
		send_range(32'h7FFF_FFFF, 32'h8000_0000);
		idle_cycles(3);
		send_range(32'h0A00_0000, 32'h0AFF_FFFF);
		send_range(32'hC0A8_0001, 32'hC0A8_00FE);
		send_range(32'h0000_0005, 32'h0000_0003);
		send_range(32'hAAAA_AAAA, 32'h5555_5555);
		send_range(32'h1234_5678, 32'h1234_5678);
		send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_range(32'h0000_0000, 32'h0000_0001);
		send_range(32'h0000_0001, 32'h0000_0002);
		drain_covers();

		for (int i = 0; i < RANDOM_RANGES; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					lo = $urandom;
					hi = $urandom;
				end
				3, 4, 6: begin
					// short span above a random low, swapped now and then
					s = $urandom_range(0, 31);
					lo = $urandom;
					sum = {1'b0, lo} + {1'b0, $urandom & ((32'd1 << s) - 32'd1)};
					hi = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if ($urandom_range(0, 2) == 0) begin
						sum[31:0] = lo;
						lo = hi;
						hi = sum[31:0];
					end
				end
				5: begin
					// exactly one aligned block
					s = $urandom_range(0, 32);
					mask = (s == 32) ? 32'hFFFF_FFFF : (32'd1 << s) - 32'd1;
					lo = $urandom & ~mask;
					hi = lo | mask;
				end
				7: begin
					lo = $urandom;
					hi = lo;
				end
				8: begin
					// low with many trailing zeros, high with many trailing ones
					lo = $urandom & ~((32'd1 << $urandom_range(0, 31)) - 32'd1);
					hi = $urandom | ((32'd1 << $urandom_range(0, 31)) - 32'd1);
				end
				default: begin
					lo = edge_word();
					hi = ($urandom_range(0, 1) == 0) ? edge_word() : $urandom;
				end
			endcase
			send_range(lo, hi);
			if (i == RANDOM_RANGES / 2 || (i < 400 && $urandom_range(0, 40) == 0))
				drain_covers();
			if (i < 400 && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 19));
		end

		drain_covers();
		repeat (70) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
